@@ hdl/dbdlp_pkg.sv @@
// Shared types and constants for the two-button debouncer with long-press detection.
// No dependencies; every other file of the block depends on this package.
package dbdlp_pkg;

  localparam int TimeMsBits = 32;
  localparam int TimeBits   = 32;
  localparam int MsBits     = 16;
  localparam int PaddrBits  = 4;
  localparam int PdataBits  = 32;

  localparam logic              ActiveLowReset = 1'b1;
  localparam logic [MsBits-1:0] DebounceReset  = 16'd30;
  localparam logic [MsBits-1:0] LongPressReset = 16'd800;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] RegActiveLow = 2'd0;
  localparam logic [1:0] RegDebounce  = 2'd1;
  localparam logic [1:0] RegLongPress = 2'd2;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvShort = 2'd1,
    EvLong  = 2'd2
  } event_e;

  typedef struct packed {
    logic              active_low;
    logic [MsBits-1:0] debounce_ms;
    logic [MsBits-1:0] long_press_ms;
  } cfg_t;

endpackage

@@ hdl/dbdlp_if.sv @@
// Valid/ready channel interfaces for samples in and events out.
// Depends on dbdlp_pkg.
interface dbdlp_in_if;
  logic                              valid;
  logic                              ready;
  logic [dbdlp_pkg::TimeMsBits-1:0]  time_ms;
  logic                              raw_level_one;
  logic                              raw_level_two;

  modport source (output valid, time_ms, raw_level_one, raw_level_two, input ready);
  modport sink   (input valid, time_ms, raw_level_one, raw_level_two, output ready);
endinterface

interface dbdlp_out_if;
  logic              valid;
  logic              ready;
  dbdlp_pkg::event_e event_one;
  dbdlp_pkg::event_e event_two;

  modport source (output valid, event_one, event_two, input ready);
  modport sink   (input valid, event_one, event_two, output ready);
endinterface

@@ hdl/dbdlp_lane.sv @@
// Per-button lane: polarity, debounce timer and press classification.
// Depends on dbdlp_pkg.
module dbdlp_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [dbdlp_pkg::TimeBits-1:0]   now_i,
  input  logic                             raw_i,
  input  dbdlp_pkg::cfg_t                  cfg_i,
  output dbdlp_pkg::event_e                event_o
);
  import dbdlp_pkg::*;

  logic                stable_q, stable_d;
  logic                fired_q, fired_d;
  logic [TimeBits-1:0] hold_q, hold_d;
  logic [TimeBits-1:0] change_q, change_d;

  logic                down;
  logic [TimeBits-1:0] change_age;
  logic [TimeBits-1:0] hold_age;
  logic                settled;
  logic                long_hit;

  assign down       = cfg_i.active_low ? ~raw_i : raw_i;
  assign change_age = now_i - change_q;
  assign hold_age   = now_i - hold_q;
  assign settled    = change_age >= {{(TimeBits-MsBits){1'b0}}, cfg_i.debounce_ms};
  assign long_hit   = hold_age >= {{(TimeBits-MsBits){1'b0}}, cfg_i.long_press_ms};

  always_comb begin
    stable_d = stable_q;
    fired_d  = fired_q;
    hold_d   = hold_q;
    change_d = now_i;
    event_o  = EvNone;
    // Hold the change timer only while a differing reading has not yet settled
    if ((down != stable_q) && !settled) begin
      change_d = change_q;
    end else begin
      stable_d = down;
    end
    if (stable_d && !stable_q) begin
      hold_d  = now_i;
      fired_d = 1'b0;
    end
    if (stable_d && stable_q && !fired_q && long_hit) begin
      fired_d = 1'b1;
      event_o = EvLong;
    end
    if (!stable_d && stable_q && !fired_q) begin
      event_o = EvShort;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      fired_q  <= 1'b0;
      hold_q   <= '0;
      change_q <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      fired_q  <= fired_d;
      hold_q   <= hold_d;
      change_q <= change_d;
    end
  end

endmodule

@@ hdl/dbdlp_merge.sv @@
// Merge stage: pairs the lane events into one result and buffers it in a
// two-entry output register / skid pair. Depends on dbdlp_pkg and dbdlp_if.
module dbdlp_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dbdlp_pkg::event_e  event_one_i,
  input  dbdlp_pkg::event_e  event_two_i,
  output logic               ready_o,
  dbdlp_out_if.source        out_o
);
  import dbdlp_pkg::*;

  logic   main_v_q, main_v_d;
  logic   skid_v_q, skid_v_d;
  event_e main_one_q, main_one_d, main_two_q, main_two_d;
  event_e skid_one_q, skid_one_d, skid_two_q, skid_two_d;
  logic   pop;

  assign pop           = main_v_q && out_o.ready;
  assign ready_o       = !skid_v_q;
  assign out_o.valid     = main_v_q;
  assign out_o.event_one = main_one_q;
  assign out_o.event_two = main_two_q;

  always_comb begin
    main_v_d   = main_v_q;
    skid_v_d   = skid_v_q;
    main_one_d = main_one_q;
    main_two_d = main_two_q;
    skid_one_d = skid_one_q;
    skid_two_d = skid_two_q;
    if (pop) begin
      if (skid_v_q) begin
        main_one_d = skid_one_q;
        main_two_d = skid_two_q;
        skid_v_d   = 1'b0;
      end else begin
        main_v_d   = push_i;
        main_one_d = event_one_i;
        main_two_d = event_two_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_d   = 1'b1;
        skid_one_d = event_one_i;
        skid_two_d = event_two_i;
      end else begin
        main_v_d   = 1'b1;
        main_one_d = event_one_i;
        main_two_d = event_two_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_one_q <= main_one_d;
    main_two_q <= main_two_d;
    skid_one_q <= skid_one_d;
    skid_two_q <= skid_two_d;
  end

endmodule

@@ hdl/dual_button_debounce_long_press.sv @@
// Two-button debouncer with short/long press detection: one sample request
// per clock, with no bubbles while results are taken. A request is accepted
// at any edge where the output skid entry is empty, so the block sustains
// one request per cycle while results are taken; each result is registered.
// The per-cycle cost is set by the two button lanes, each doing two 32-bit
// wrapping subtract-and-compare operations against the debounce and
// long-press times. Up to two results are buffered when the result side
// stalls; after that, in ready drops until a result is taken. Registers
// (APB, byte address 4*index): 0 active_low (reset 1), 1 debounce_ms
// (reset 30), 2 long_press_ms (reset 800). Write them only while idle.
// Depends on dbdlp_pkg, dbdlp_if, dbdlp_lane and dbdlp_merge.
module dual_button_debounce_long_press (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dbdlp_in_if.sink                          in_i,
  dbdlp_out_if.source                       out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dbdlp_pkg::PaddrBits-1:0]   paddr,
  input  logic [dbdlp_pkg::PdataBits-1:0]   pwdata,
  output logic [dbdlp_pkg::PdataBits-1:0]   prdata,
  output logic                              pready
);
  import dbdlp_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                accept;
  logic                merge_ready;
  logic [TimeBits-1:0] now;
  event_e              ev_one, ev_two;

  // ---------------------------------------------------------------------
  // Configuration port: pready held high, decode on the word index
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegActiveLow: cfg_d.active_low    = pwdata[0];
        RegDebounce:  cfg_d.debounce_ms   = pwdata[MsBits-1:0];
        RegLongPress: cfg_d.long_press_ms = pwdata[MsBits-1:0];
        default:      cfg_d = cfg_q;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegActiveLow: prdata = {{(PdataBits-1){1'b0}}, cfg_q.active_low};
      RegDebounce:  prdata = {{(PdataBits-MsBits){1'b0}}, cfg_q.debounce_ms};
      RegLongPress: prdata = {{(PdataBits-MsBits){1'b0}}, cfg_q.long_press_ms};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low    <= ActiveLowReset;
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------
  // Request side: both lanes advance together on an accepted sample
  // ---------------------------------------------------------------------
  assign in_i.ready = merge_ready;
  assign accept     = in_i.valid && merge_ready;
  assign now        = in_i.time_ms[TimeBits-1:0];

  dbdlp_lane u_lane_one (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .now_i    (now),
    .raw_i    (in_i.raw_level_one),
    .cfg_i    (cfg_q),
    .event_o  (ev_one)
  );

  dbdlp_lane u_lane_two (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .now_i    (now),
    .raw_i    (in_i.raw_level_two),
    .cfg_i    (cfg_q),
    .event_o  (ev_two)
  );

  // ---------------------------------------------------------------------
  // Result side: combine lane events and buffer them for the sink
  // ---------------------------------------------------------------------
  dbdlp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .event_one_i (ev_one),
    .event_two_i (ev_two),
    .ready_o     (merge_ready),
    .out_o       (out_o)
  );

endmodule

@@ hdl/dbdlp_checker.sv @@
// Port-level checks for dual_button_debounce_long_press, bound to the top level.
// Depends on dbdlp_pkg for the event codes.
module dbdlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_one,
  input logic [1:0] event_two
);
  import dbdlp_pkg::*;

  // A stalled result stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(event_one) && $stable(event_two))
    else $error("stalled result changed or dropped");

  // Back-pressure on requests only once a result is already waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("request side stalled with no result pending");

  // Every accepted request leaves a result on offer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // Offered events carry only defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (event_one == EvNone || event_one == EvShort || event_one == EvLong) &&
                  (event_two == EvNone || event_two == EvShort || event_two == EvLong))
    else $error("undefined event code on output");

endmodule

bind dual_button_debounce_long_press dbdlp_checker u_dbdlp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .event_one (out_o.event_one),
  .event_two (out_o.event_two)
);

@@ test/tb_top.sv @@
// Self-checking bench for the two-button debouncer with long-press detection.
// Drives sample requests and APB register writes, predicts events per button.
// Depends on dbdlp_pkg, dbdlp_if and dual_button_debounce_long_press.
`timescale 1ns / 100ps

module tb_top;
  import dbdlp_pkg::*;

  localparam int         CycleLimit = 400000;
  localparam int         ShowFaults = 10;
  // Address 12 lies past the last register; writes there must change nothing.
  localparam logic [1:0] RegSpare   = 2'd3;

  typedef struct packed {
    logic [TimeMsBits-1:0] time_ms;
    logic                  raw_one;
    logic                  raw_two;
  } sample_t;

  typedef struct packed {
    event_e one;
    event_e two;
  } press_pair_t;

  // Stage of the scripted press on one button.
  typedef enum logic [1:0] {
    SegRest,
    SegBounceIn,
    SegHold,
    SegBounceOut
  } seg_e;

  logic clk_i;
  logic rst_n;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata;
  logic [PdataBits-1:0] prdata;
  logic                 pready;

  dbdlp_in_if  in_bus ();
  dbdlp_out_if out_bus ();

  dual_button_debounce_long_press u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Sample requests waiting to be offered, and the events they must produce.
  sample_t     pending_samples[$];
  press_pair_t expected_events[$];

  // Register values as the block should currently hold them.
  cfg_t model_cfg;

  // Debounce state of both buttons, index 0 is button one.
  logic            btn_stable [2];
  logic            btn_prev   [2];
  logic            btn_long   [2];
  logic [TimeBits-1:0] btn_hold   [2];
  logic [TimeBits-1:0] btn_change [2];

  // Stimulus script state.
  logic [TimeMsBits-1:0] now_ms;
  seg_e                  seg_state [2];
  int                    seg_left  [2];

  int fault_cnt;
  int cycle_cnt;

  // Advance one button by one sample and return its event.
  function automatic event_e debounce_button(int b, logic [TimeBits-1:0] now, logic raw);
    logic                down;
    logic [TimeBits-1:0] since;
    event_e              ev;
    down = model_cfg.active_low ? ~raw : raw;
    ev   = EvNone;
    // A differing reading is taken only once the change timer has run out;
    // an agreeing reading restarts the timer.
    if (down != btn_stable[b]) begin
      since = now - btn_change[b];
      if (since >= TimeBits'(model_cfg.debounce_ms)) begin
        btn_stable[b] = down;
        btn_change[b] = now;
      end
    end else begin
      btn_change[b] = now;
    end
    if (btn_stable[b] && !btn_prev[b]) begin
      btn_hold[b] = now;
      btn_long[b] = 1'b0;
    end
    // The long press needs a previous pressed step, so it never fires on
    // the step where the press was accepted.
    since = now - btn_hold[b];
    if (btn_stable[b] && btn_prev[b] && !btn_long[b] &&
        since >= TimeBits'(model_cfg.long_press_ms)) begin
      btn_long[b] = 1'b1;
      ev          = EvLong;
    end
    if (!btn_stable[b] && btn_prev[b] && !btn_long[b]) begin
      ev = EvShort;
    end
    btn_prev[b] = btn_stable[b];
    return ev;
  endfunction

  // Length of the next idle gap: mostly none or short, a few long, and now
  // and then a calm stretch with no gaps at all.
  function automatic int idle_span(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_sample(logic [TimeMsBits-1:0] t, logic r1, logic r2);
    pending_samples.push_back('{time_ms: t, raw_one: r1, raw_two: r2});
  endtask

  // Scripted press traffic: each button cycles rest, bounce, hold, bounce,
  // with time steps scaled to the current debounce and long-press times.
  task automatic queue_button_traffic(int count);
    int   fine_max;
    int   coarse_max;
    int   r;
    int   b;
    logic lvl [2];
    logic pressed_lvl;
    fine_max    = int'(model_cfg.debounce_ms) / 4 + 1;
    coarse_max  = int'(model_cfg.long_press_ms) / 5 + 1;
    pressed_lvl = ~model_cfg.active_low;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        now_ms = $urandom;
      end else if (r < 70) begin
        now_ms += $urandom_range(1, fine_max);
      end else begin
        now_ms += $urandom_range(1, coarse_max);
      end
      for (b = 0; b < 2; b++) begin
        if (seg_left[b] == 0) begin
          seg_state[b] = seg_state[b].next();
          case (seg_state[b])
            SegRest: begin
              seg_left[b] = $urandom_range(1, 8);
            end
            SegHold: begin
              seg_left[b] = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 6)
                                                       : $urandom_range(5, 40);
            end
            default: begin
              seg_left[b] = $urandom_range(1, 4);
            end
          endcase
        end
        seg_left[b]--;
        case (seg_state[b])
          SegRest: lvl[b] = ~pressed_lvl;
          SegHold: lvl[b] = pressed_lvl;
          default: lvl[b] = 1'($urandom_range(0, 1));
        endcase
        // Sprinkle glitches over the script.
        if ($urandom_range(0, 19) == 0) begin
          lvl[b] = 1'($urandom_range(0, 1));
        end
      end
      queue_sample(now_ms, lvl[0], lvl[1]);
    end
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic write_reg(logic [1:0] idx, logic [PdataBits-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrBits'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegActiveLow: model_cfg.active_low    = data[0];
      RegDebounce:  model_cfg.debounce_ms   = data[MsBits-1:0];
      RegLongPress: model_cfg.long_press_ms = data[MsBits-1:0];
      default: ;
    endcase
  endtask

  // Write all three registers; the upper data bits carry junk on purpose.
  task automatic apply_settings(logic al, logic [MsBits-1:0] db, logic [MsBits-1:0] lp);
    write_reg(RegActiveLow, {31'($urandom), al});
    write_reg(RegDebounce,  {16'($urandom), db});
    write_reg(RegLongPress, {16'($urandom), lp});
  endtask

  // Hold until every request is taken and every event has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_bus.valid || expected_events.size() != 0);
  endtask

  // Driver: offer queued samples, predict on each accepted request.
  int drv_gap;
  int drv_calm;

  always @(posedge clk_i) begin : drive_samples
    logic        nxt_valid;
    sample_t     offer;
    press_pair_t want;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      nxt_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        offer     = '{time_ms: in_bus.time_ms, raw_one: in_bus.raw_level_one,
                      raw_two: in_bus.raw_level_two};
        want.one  = debounce_button(0, offer.time_ms, offer.raw_one);
        want.two  = debounce_button(1, offer.time_ms, offer.raw_two);
        expected_events.push_back(want);
        nxt_valid = 1'b0;
        drv_gap   = idle_span(drv_calm);
      end
      // Keep valid high across back-to-back requests: one assignment per edge.
      if (!nxt_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_samples.size() > 0) begin
          offer                 = pending_samples.pop_front();
          in_bus.time_ms       <= offer.time_ms;
          in_bus.raw_level_one <= offer.raw_one;
          in_bus.raw_level_two <= offer.raw_two;
          nxt_valid             = 1'b1;
        end
      end
      in_bus.valid <= nxt_valid;
    end
  end

  // Monitor: check each taken result, then pick the next ready level.
  int rx_count;
  int rx_stall;
  int rx_calm;
  int rx_holdoff;

  always @(posedge clk_i) begin : check_events
    logic        nxt_ready;
    press_pair_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_events.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= ShowFaults) begin
            $display("unexpected result: one=%0d two=%0d",
                     out_bus.event_one, out_bus.event_two);
          end
        end else begin
          want = expected_events.pop_front();
          if (out_bus.event_one !== want.one || out_bus.event_two !== want.two) begin
            fault_cnt++;
            if (fault_cnt <= ShowFaults) begin
              $display("event mismatch #%0d: expected one=%0d two=%0d, got one=%0d two=%0d",
                       rx_count, want.one, want.two, out_bus.event_one, out_bus.event_two);
            end
          end
        end
        rx_count++;
        // Long hold-off twice in the run, so the block fills and stalls its input.
        if (rx_count == 150 || rx_count == 500) begin
          rx_holdoff = 300;
        end
      end
      if (rx_holdoff > 0) begin
        rx_holdoff--;
        nxt_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        rx_stall  = idle_span(rx_calm);
      end
      out_bus.ready <= nxt_ready;
    end
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[dual_button_debounce_long_press] ERROR");
      $finish;
    end
  end

  initial begin : main_sequence
    int b;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.time_ms       = '0;
    in_bus.raw_level_one = 1'b1;
    in_bus.raw_level_two = 1'b1;
    out_bus.ready        = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    fault_cnt            = 0;
    cycle_cnt            = 0;
    drv_gap              = 0;
    drv_calm             = 0;
    rx_count             = 0;
    rx_stall             = 0;
    rx_calm              = 0;
    rx_holdoff           = 0;
    now_ms               = '0;

    model_cfg.active_low    = ActiveLowReset;
    model_cfg.debounce_ms   = DebounceReset;
    model_cfg.long_press_ms = LongPressReset;
    for (b = 0; b < 2; b++) begin
      btn_stable[b] = 1'b0;
      btn_prev[b]   = 1'b0;
      btn_long[b]   = 1'b0;
      btn_hold[b]   = '0;
      btn_change[b] = '0;
      seg_state[b]  = SegBounceOut;
      seg_left[b]   = 0;
    end

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset settings, active low. Press both buttons across the timestamp
    // wrap, give a short press on button two and a long one on button one.
    queue_sample(32'h0000_0000, 1'b1, 1'b1);
    queue_sample(32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
    queue_sample(32'h0000_0014, 1'b0, 1'b1);
    queue_sample(32'h0000_0330, 1'b0, 1'b0);
    queue_sample(32'h0000_0331, 1'b1, 1'b0);
    queue_sample(32'h0000_0350, 1'b1, 1'b1);
    queue_button_traffic(60);
    wait_drained();

    // Zero debounce and zero long-press time, active high; also poke the
    // address past the register file.
    apply_settings(1'b0, 16'd0, 16'd0);
    write_reg(RegSpare, $urandom);
    now_ms = 32'd100;
    queue_sample(32'd100, 1'b1, 1'b0);
    queue_sample(32'd100, 1'b1, 1'b0);
    queue_sample(32'd100, 1'b0, 1'b1);
    queue_sample(32'd101, 1'b0, 1'b0);
    queue_button_traffic(80);
    wait_drained();

    // Largest times: changes need huge timestamp steps.
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    queue_sample(32'h0000_0000, 1'b0, 1'b1);
    queue_sample(32'h0001_0000, 1'b0, 1'b0);
    queue_sample(32'h0002_0000, 1'b0, 1'b0);
    now_ms = $urandom;
    queue_button_traffic(100);
    wait_drained();

    apply_settings(1'b0, 16'd5, 16'd100);
    queue_button_traffic(150);
    wait_drained();

    apply_settings(ActiveLowReset, DebounceReset, LongPressReset);
    queue_button_traffic(130);
    wait_drained();

    apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 400)));
    queue_button_traffic(130);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (8) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("[dual_button_debounce_long_press] OK");
    end else begin
      $display("[dual_button_debounce_long_press] ERROR");
    end
    $finish;
  end

endmodule
